// ===== src/kpd_pkg.sv =====
package kpd_pkg;

    localparam int unsigned SettleWidth   = 8;
    localparam int unsigned DebounceWidth = 20;
    localparam int unsigned CodeWidth     = 8;

    localparam logic [SettleWidth-1:0]   SettleReset   = 8'd2;
    localparam logic [DebounceWidth-1:0] DebounceReset = 20'd20000;

    // register indexes on the configuration port
    localparam logic RegSettle   = 1'b0;
    localparam logic RegDebounce = 1'b1;

    typedef struct packed {
        logic [SettleWidth-1:0]   settle_ticks;
        logic [DebounceWidth-1:0] debounce_ticks;
    } kpd_cfg_t;

    typedef struct packed {
        logic [3:0]           row_drive;
        logic                 key_valid;
        logic [CodeWidth-1:0] key_code;
    } kpd_result_t;

    // keymap lookup: one set column gives the key, anything else gives zero
    function automatic logic [CodeWidth-1:0] key_lookup(input logic [1:0] row,
                                                         input logic [3:0] col);
        logic [CodeWidth-1:0] code;
        code = '0;
        case (row)
            2'd0:
            begin
                case (col)
                    4'b0001: code = 8'h37;
                    4'b0010: code = 8'h38;
                    4'b0100: code = 8'h39;
                    4'b1000: code = 8'h2F;
                    default: code = '0;
                endcase
            end
            2'd1:
            begin
                case (col)
                    4'b0001: code = 8'h34;
                    4'b0010: code = 8'h35;
                    4'b0100: code = 8'h36;
                    4'b1000: code = 8'h2A;
                    default: code = '0;
                endcase
            end
            2'd2:
            begin
                case (col)
                    4'b0001: code = 8'h31;
                    4'b0010: code = 8'h32;
                    4'b0100: code = 8'h33;
                    4'b1000: code = 8'h2D;
                    default: code = '0;
                endcase
            end
            default:
            begin
                case (col)
                    4'b0001: code = 8'h2E;
                    4'b0010: code = 8'h30;
                    4'b0100: code = 8'h3D;
                    4'b1000: code = 8'h2B;
                    default: code = '0;
                endcase
            end
        endcase
        return code;
    endfunction

endpackage

// ===== src/kpd_regs.sv =====
module kpd_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output kpd_pkg::kpd_cfg_t cfg
);
    import kpd_pkg::*;

    logic [SettleWidth-1:0]   settle_reg;
    logic [DebounceWidth-1:0] debounce_reg;
    logic                     wr_en;
    logic                     reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg   <= SettleReset;
            debounce_reg <= DebounceReset;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                RegSettle:   settle_reg   <= pwdata[SettleWidth-1:0];
                RegDebounce: debounce_reg <= pwdata[DebounceWidth-1:0];
                default:     settle_reg   <= settle_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            RegSettle:   prdata = {{(32-SettleWidth){1'b0}}, settle_reg};
            RegDebounce: prdata = {{(32-DebounceWidth){1'b0}}, debounce_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.settle_ticks   = settle_reg;
    assign cfg.debounce_ticks = debounce_reg;

endmodule

// ===== src/kpd_core.sv =====
module kpd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [3:0]           column_sense,
    input  kpd_pkg::kpd_cfg_t    cfg,
    output kpd_pkg::kpd_result_t result
);
    import kpd_pkg::*;

    typedef enum logic [2:0] {
        REL_SCAN    = 3'd0,
        REL_WAIT    = 3'd1,
        REL_CHECK   = 3'd2,
        PRESS_SCAN  = 3'd3,
        PRESS_WAIT  = 3'd4,
        PRESS_CHECK = 3'd5
    } phase_t;

    phase_t                   phase_reg,  phase_next;
    logic                     settle_reg, settle_next;
    logic [1:0]               row_reg,    row_next;
    logic [DebounceWidth-1:0] tick_reg,   tick_next;
    logic [CodeWidth-1:0]     first_reg,  first_next;
    logic [3:0]               drive_reg,  drive_next;

    // scan outcome for this tick
    logic                     s_settle;
    logic [1:0]               s_row;
    logic [DebounceWidth-1:0] s_tick;
    logic [3:0]               s_drive;
    logic                     s_done;
    logic [CodeWidth-1:0]     s_res;
    logic [1:0]               row_inc;
    // debounce wait outcome
    logic                     w_done;
    logic [DebounceWidth-1:0] w_tick;
    logic [DebounceWidth-1:0] tick_inc;

    logic                     valid_out;
    logic [CodeWidth-1:0]     code_out;

    assign tick_inc = tick_reg + 1'b1;
    assign row_inc  = row_reg + 1'b1;
    assign w_done   = tick_reg >= cfg.debounce_ticks;
    assign w_tick   = w_done ? tick_reg : tick_inc;

    always_comb
    begin
        s_settle = settle_reg;
        s_row    = row_reg;
        s_tick   = tick_reg;
        s_drive  = drive_reg;
        s_done   = 1'b0;
        s_res    = '0;
        if (!settle_reg)
        begin
            if (column_sense == 4'd0)
            begin
                s_done  = 1'b1;
                s_drive = 4'd0;
                s_row   = 2'd0;
            end
            else
            begin
                s_row    = 2'd0;
                s_drive  = 4'b1110;
                s_tick   = '0;
                s_settle = 1'b1;
            end
        end
        else if (tick_reg < {{(DebounceWidth-SettleWidth){1'b0}}, cfg.settle_ticks})
        begin
            s_tick = tick_inc;
        end
        else if (column_sense != 4'd0 || row_reg == 2'd3)
        begin
            s_done   = 1'b1;
            s_res    = key_lookup(row_reg, column_sense);
            s_settle = 1'b0;
            s_drive  = 4'd0;
            s_row    = 2'd0;
        end
        else
        begin
            // drive the next row alone, active low
            s_row   = row_inc;
            s_drive = ~(4'b0001 << row_inc);
            s_tick  = '0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        settle_next = s_settle;
        row_next    = s_row;
        tick_next   = s_tick;
        first_next  = first_reg;
        drive_next  = s_drive;
        valid_out   = 1'b0;
        code_out    = '0;
        case (phase_reg)
            REL_WAIT, PRESS_WAIT:
            begin
                settle_next = settle_reg;
                row_next    = row_reg;
                drive_next  = drive_reg;
                tick_next   = w_tick;
                if (w_done)
                begin
                    phase_next = (phase_reg == REL_WAIT) ? REL_CHECK : PRESS_CHECK;
                end
            end
            REL_CHECK:
            begin
                if (s_done)
                begin
                    phase_next = (s_res == '0) ? PRESS_SCAN : REL_SCAN;
                end
            end
            PRESS_SCAN:
            begin
                if (s_done && s_res != '0)
                begin
                    first_next = s_res;
                    tick_next  = '0;
                    phase_next = PRESS_WAIT;
                end
            end
            PRESS_CHECK:
            begin
                if (s_done)
                begin
                    if (s_res == first_reg)
                    begin
                        valid_out  = 1'b1;
                        code_out   = s_res;
                        phase_next = REL_SCAN;
                    end
                    else
                    begin
                        phase_next = PRESS_SCAN;
                    end
                end
            end
            default:
            begin
                phase_next = REL_SCAN;
                if (s_done && s_res == '0)
                begin
                    tick_next  = '0;
                    phase_next = REL_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= REL_SCAN;
            settle_reg <= 1'b0;
            row_reg    <= 2'd0;
            tick_reg   <= '0;
            first_reg  <= '0;
            drive_reg  <= 4'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            settle_reg <= settle_next;
            row_reg    <= row_next;
            tick_reg   <= tick_next;
            first_reg  <= first_next;
            drive_reg  <= drive_next;
        end
    end

    assign result.row_drive = drive_next;
    assign result.key_valid = valid_out;
    assign result.key_code  = code_out;

endmodule

// ===== src/matrix_keypad_scanner_debounce.sv =====
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------
// in       | in_valid / in_ready    | column_sense[3:0]
// out      | out_valid / out_ready  | row_drive[3:0], key_valid, key_code[7:0]
// config   | APB psel/penable/...   | 0x0 settle_ticks, 0x4 debounce_ticks
//
// One tick per cycle while requests are accepted: the scan and debounce step
// runs between the state registers and the output register, so a request is
// taken each cycle in_ready is high, with its result in the next cycle.
// in_ready drops only while a result is held and out_ready is low.
// Reset clears the core to the release scan with all rows driven, not out_reg.
module matrix_keypad_scanner_debounce (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  column_sense,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  row_drive,
    output logic        key_valid,
    output logic [7:0]  key_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kpd_pkg::*;

    kpd_cfg_t    cfg;
    kpd_result_t result;
    logic        accept;
    logic        out_valid_reg;
    kpd_result_t out_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    kpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kpd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .column_sense (column_sense),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_drive = out_reg.row_drive;
    assign key_valid = out_reg.key_valid;
    assign key_code  = out_reg.key_code;

endmodule

// ===== src/kpd_checker.sv =====
module kpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] row_drive,
    input logic       key_valid,
    input logic [7:0] key_code
);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with no result held");

    a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted request gave no result");

    a_no_key_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !key_valid) |-> key_code == 8'd0)
        else $error("key_code set without key_valid");

    a_drive_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_drive == 4'd0 || $countones(row_drive) == 3))
        else $error("row_drive drives more than one row but not all");

    a_report_all_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_valid) |-> row_drive == 4'd0)
        else $error("key reported while scan still drives a single row");

endmodule

bind matrix_keypad_scanner_debounce kpd_checker u_kpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_drive (row_drive),
    .key_valid (key_valid),
    .key_code  (key_code)
);
